// ===== hdl/gas_pkg.sv =====
// Shared types and constants for the grid path search core.
// Holds default sizes, configuration reset values and indexes, item and status codes and the sequencer states.
// No dependencies.
package gas_pkg;

    // default sizes handed to the top level
    localparam int ROWS_DEF        = 32;
    localparam int COLS_DEF        = 16;
    localparam int NODE_DEPTH_DEF  = 4096;
    localparam int H_FRAC_BITS_DEF = 8;

    // reset values of the configuration registers
    localparam logic [5:0] ROWS_IN_USE_RST = 6'd20;
    localparam logic [4:0] COLS_IN_USE_RST = 5'd16;

    // configuration register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // item kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_BLOCKED  = 3'd2;
    localparam logic [2:0] ST_ALREADY  = 3'd3;
    localparam logic [2:0] ST_NO_PATH  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;
    localparam logic [2:0] ST_OK       = 3'd6;

    // sequencer states
    typedef enum logic [4:0] {
        S_MAPCLR,
        S_IDLE,
        S_PRD,
        S_BLK1,
        S_BLK2,
        S_CLR,
        S_POP,
        S_POP_Q,
        S_SD,
        S_SD_Q,
        S_SD_END,
        S_NODE_Q,
        S_CL_Q,
        S_NB,
        S_NB_Q,
        S_H,
        S_SU,
        S_SU_Q,
        S_PW,
        S_PW_Q
    } state_t;

endpackage

// ===== hdl/gas_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Used for the distance estimate of the path search; no package use.
// Gives floor(sqrt(rad)) and a one-cycle done pulse.
module gas_sqrt #(
    parameter int YW = 40
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [YW-1:0]     rad,
    output logic              done,
    output logic [YW/2-1:0]   root
);

    localparam int SW  = YW / 2;
    localparam int CNW = $clog2(SW + 1);

    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [CNW-1:0]  cnt_reg, cnt_next;
    logic [YW-1:0]   rad_reg, rad_next;
    logic [SW+1:0]   rem_reg, rem_next;
    logic [SW-1:0]   root_reg, root_next;
    logic [SW+1:0]   rem_sh;
    logic [SW+1:0]   trial;

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_reg[SW-1:0], rad_reg[YW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (go)
        begin
            run_next  = 1'b1;
            cnt_next  = CNW'(SW);
            rad_next  = rad;
            rem_next  = '0;
            root_next = '0;
        end
        else if (run_reg)
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[SW-2:0], 1'b0};
            end
            rad_next = rad_reg << 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // hold datapath
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hdl/grid_astar_path_search_core.sv =====
// Top level of the grid path search core: sequencer, map, closed marks,
// node store, open heap and path store. Uses gas_pkg and gas_sqrt.
//
// Usage: an item word is taken at a clock edge where start is high and busy
// is low. kind selects a map cell write, a search, or a path step read.
// Every item gives one result word, shown for one cycle with done high;
// the receiver cannot stall, so the word must be taken in that cycle.
// A cell write or a rejected item answers in the cycle after it is taken; a path
// step read passes through S_PRD first. A search clears the closed marks first (one
// cell per cycle), then pops the heap: each pop sifts the hole down through the
// heap, and each pushed neighbour waits for the distance root from gas_sqrt and
// then climbs the heap from the new leaf.
// After reset the map is swept to open, with busy high.
// Configuration writes through cfg_we/cfg_idx/cfg_data take effect at once
// and are meant for times when the core is idle.
module grid_astar_path_search_core #(
    parameter int ROWS        = gas_pkg::ROWS_DEF,
    parameter int COLS        = gas_pkg::COLS_DEF,
    parameter int NODE_DEPTH  = gas_pkg::NODE_DEPTH_DEF,
    parameter int H_FRAC_BITS = gas_pkg::H_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [4:0]  cell_row,
    input  logic [3:0]  cell_col,
    input  logic        wall,
    input  logic [4:0]  start_row,
    input  logic [3:0]  start_col,
    input  logic [4:0]  goal_row,
    input  logic [3:0]  goal_col,
    input  logic [8:0]  step_index,
    output logic        done,
    output logic [2:0]  status,
    output logic [9:0]  path_length,
    output logic [4:0]  step_row,
    output logic [3:0]  step_col,
    output logic [15:0] expansions,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [5:0]  cfg_data
);

    localparam int CELLS  = ROWS * COLS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int PW     = $clog2(CELLS + 1);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int RUW    = (RW + 1 > 6) ? RW + 1 : 6;
    localparam int CUW    = (CW + 1 > 5) ? CW + 1 : 5;
    localparam int NW     = $clog2(NODE_DEPTH);
    localparam int GW     = NW + 1;
    localparam int DW     = (RW > CW) ? RW : CW;
    localparam int D2W    = 2 * DW + 1;
    localparam int YW0    = D2W + 2 * H_FRAC_BITS + 2;
    localparam int YW     = YW0 + (YW0 % 2);
    localparam int SW     = YW / 2;
    localparam int FW     = ((GW + H_FRAC_BITS > SW) ? GW + H_FRAC_BITS : SW) + 1;
    localparam int HEW    = FW + NW;

    typedef struct packed {
        logic [RW-1:0] row;
        logic [CW-1:0] col;
        logic          has_par;
        logic [NW-1:0] par;
        logic [GW-1:0] g;
    } node_t;

    function automatic logic [CELL_W-1:0] cell_of(input logic [RW-1:0] r,
                                                   input logic [CW-1:0] c);
        cell_of = CELL_W'(int'(r) * COLS + int'(c));
    endfunction

    // configuration registers
    logic [5:0] rows_reg;
    logic [4:0] cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= gas_pkg::ROWS_IN_USE_RST;
            cols_reg <= gas_pkg::COLS_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                gas_pkg::REG_ROWS: rows_reg <= cfg_data;
                gas_pkg::REG_COLS: cols_reg <= cfg_data[4:0];
                default:           rows_reg <= rows_reg;
            endcase
        end
    end

    logic [RUW-1:0] nr_use;
    logic [CUW-1:0] nc_use;

    assign nr_use = (RUW'(rows_reg) > RUW'(ROWS)) ? RUW'(ROWS) : RUW'(rows_reg);
    assign nc_use = (CUW'(cols_reg) > CUW'(COLS)) ? CUW'(COLS) : CUW'(cols_reg);

    // sequencer registers
    gas_pkg::state_t state_reg, state_next;
    logic [CELL_W-1:0] clr_reg, clr_next;
    logic [RW-1:0]     sr_reg, sr_next, gr_reg, gr_next;
    logic [CW-1:0]     sc_reg, sc_next, gc_reg, gc_next;
    logic [HEW-1:0]    top_reg, top_next, last_reg, last_next, ent_reg, ent_next;
    logic [NW-1:0]     hidx_reg, hidx_next;
    logic [NW:0]       hcnt_reg, hcnt_next, ncnt_reg, ncnt_next;
    logic [NW-1:0]     cur_reg, cur_next;
    logic [RW-1:0]     cur_r_reg, cur_r_next;
    logic [CW-1:0]     cur_c_reg, cur_c_next;
    logic [GW-1:0]     cur_g_reg, cur_g_next;
    logic [1:0]        di_reg, di_next, dj_reg, dj_next;
    logic [PW-1:0]     pcnt_reg, pcnt_next;
    logic [CELL_W-1:0] walk_reg, walk_next;
    logic [15:0]       exp_reg, exp_next;
    logic [2:0]        status_reg, status_next;
    logic [4:0]        srow_reg, srow_next;
    logic [3:0]        scol_reg, scol_next;
    logic              done_reg, done_next;

    // memory ports
    logic              map_we, map_wd, map_q;
    logic [CELL_W-1:0] map_wa, map_ra;
    logic              cls_we, cls_wd, cls_q;
    logic [CELL_W-1:0] cls_wa, cls_ra;
    logic              nd_we;
    logic [NW-1:0]     nd_wa, nd_ra;
    node_t             nd_wd, nd_q;
    logic              hp_we;
    logic [NW-1:0]     hp_wa, hp_ra0, hp_ra1;
    logic [HEW-1:0]    hp_wd, hp_q0, hp_q1;
    logic              pt_we;
    logic [CELL_W-1:0] pt_wa, pt_ra;
    logic [RW+CW-1:0]  pt_wd, pt_q;

    logic              map_mem [CELLS];
    logic              cls_mem [CELLS];
    node_t             nd_mem  [NODE_DEPTH];
    logic [HEW-1:0]    hp_mem  [NODE_DEPTH];
    logic [RW+CW-1:0]  pt_mem  [CELLS];

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_wa] <= map_wd;
        end
        map_q <= map_mem[map_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cls_we)
        begin
            cls_mem[cls_wa] <= cls_wd;
        end
        cls_q <= cls_mem[cls_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nd_we)
        begin
            nd_mem[nd_wa] <= nd_wd;
        end
        nd_q <= nd_mem[nd_ra];
    end

    always_ff @(posedge clk)
    begin
        if (hp_we)
        begin
            hp_mem[hp_wa] <= hp_wd;
        end
        hp_q0 <= hp_mem[hp_ra0];
        hp_q1 <= hp_mem[hp_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_wa] <= pt_wd;
        end
        pt_q <= pt_mem[pt_ra];
    end

    // neighbour coordinates and bounds
    logic [RUW-1:0] ir;
    logic [CUW-1:0] jc;
    logic           nb_ok, nb_last;
    logic [RW-1:0]  nb_r, dr;
    logic [CW-1:0]  nb_c, dc;
    logic [D2W-1:0] d2;
    logic [YW-1:0]  sq_rad;
    logic           sq_go, sq_done;
    logic [SW-1:0]  sq_root;
    logic [SW:0]    hsum;
    logic [FW-1:0]  f_new;
    logic [GW-1:0]  g_new;

    assign ir      = RUW'(cur_r_reg) + RUW'(di_reg) - RUW'(1);
    assign jc      = CUW'(cur_c_reg) + CUW'(dj_reg) - CUW'(1);
    assign nb_ok   = (ir < nr_use) && (jc < nc_use) && !(di_reg == 2'd1 && dj_reg == 2'd1);
    assign nb_last = (di_reg == 2'd2) && (dj_reg == 2'd2);
    assign nb_r    = RW'(ir);
    assign nb_c    = CW'(jc);
    assign dr      = (nb_r >= gr_reg) ? nb_r - gr_reg : gr_reg - nb_r;
    assign dc      = (nb_c >= gc_reg) ? nb_c - gc_reg : gc_reg - nb_c;
    assign d2      = D2W'(dr) * D2W'(dr) + D2W'(dc) * D2W'(dc);
    assign sq_rad  = YW'(d2) << (2 * H_FRAC_BITS + 2);
    assign hsum    = {1'b0, sq_root} + (SW + 1)'(1);
    assign g_new   = cur_g_reg + 1'b1;
    assign f_new   = (FW'(g_new) << H_FRAC_BITS) + FW'(hsum[SW:1]);

    gas_sqrt #(
        .YW (YW)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (sq_go),
        .rad   (sq_rad),
        .done  (sq_done),
        .root  (sq_root)
    );

    // heap index helpers
    logic [NW:0]    lc, lc1;
    logic [NW-1:0]  par_i;
    logic           pick_r;
    logic [HEW-1:0] sv;
    logic           in_range;

    assign lc     = {hidx_reg, 1'b1};
    assign lc1    = lc + 1'b1;
    assign par_i  = (hidx_reg - 1'b1) >> 1;
    assign pick_r = (lc1 < hcnt_reg) && (hp_q1 < hp_q0);
    assign sv     = pick_r ? hp_q1 : hp_q0;
    assign in_range = (int'(cell_row) < ROWS) && (int'(cell_col) < COLS);

    // next state and memory control
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        sr_next     = sr_reg;
        sc_next     = sc_reg;
        gr_next     = gr_reg;
        gc_next     = gc_reg;
        top_next    = top_reg;
        last_next   = last_reg;
        ent_next    = ent_reg;
        hidx_next   = hidx_reg;
        hcnt_next   = hcnt_reg;
        ncnt_next   = ncnt_reg;
        cur_next    = cur_reg;
        cur_r_next  = cur_r_reg;
        cur_c_next  = cur_c_reg;
        cur_g_next  = cur_g_reg;
        di_next     = di_reg;
        dj_next     = dj_reg;
        pcnt_next   = pcnt_reg;
        walk_next   = walk_reg;
        exp_next    = exp_reg;
        status_next = status_reg;
        srow_next   = srow_reg;
        scol_next   = scol_reg;
        done_next   = 1'b0;

        map_we = 1'b0;
        map_wa = clr_reg;
        map_wd = 1'b0;
        map_ra = cell_of(nb_r, nb_c);
        cls_we = 1'b0;
        cls_wa = clr_reg;
        cls_wd = 1'b0;
        cls_ra = cell_of(nb_r, nb_c);
        nd_we  = 1'b0;
        nd_wa  = NW'(ncnt_reg);
        nd_wd  = '{row: nb_r, col: nb_c, has_par: 1'b1, par: cur_reg, g: g_new};
        nd_ra  = cur_reg;
        hp_we  = 1'b0;
        hp_wa  = hidx_reg;
        hp_wd  = ent_reg;
        hp_ra0 = NW'(lc);
        hp_ra1 = NW'(lc1);
        pt_we  = 1'b0;
        pt_wa  = walk_reg;
        pt_wd  = {nd_q.row, nd_q.col};
        pt_ra  = CELL_W'(int'(pcnt_reg) - 1 - int'(step_index));
        sq_go  = 1'b0;

        case (state_reg)
            gas_pkg::S_MAPCLR:
            begin
                // sweep the map to open after reset
                map_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CELL_W'(CELLS - 1))
                begin
                    state_next = gas_pkg::S_IDLE;
                end
            end

            gas_pkg::S_IDLE:
            begin
                if (start)
                begin
                    srow_next = '0;
                    scol_next = '0;
                    case (kind)
                        gas_pkg::KIND_WRITE:
                        begin
                            map_we      = in_range;
                            map_wa      = cell_of(RW'(cell_row), CW'(cell_col));
                            map_wd      = wall;
                            status_next = gas_pkg::ST_OK;
                            done_next   = 1'b1;
                        end
                        gas_pkg::KIND_SEARCH:
                        begin
                            sr_next = RW'(start_row);
                            sc_next = CW'(start_col);
                            gr_next = RW'(goal_row);
                            gc_next = CW'(goal_col);
                            if (RUW'(start_row) >= nr_use || CUW'(start_col) >= nc_use ||
                                RUW'(goal_row) >= nr_use || CUW'(goal_col) >= nc_use)
                            begin
                                pcnt_next   = '0;
                                status_next = gas_pkg::ST_INVALID;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                map_ra     = cell_of(RW'(start_row), CW'(start_col));
                                state_next = gas_pkg::S_BLK1;
                            end
                        end
                        gas_pkg::KIND_READ:
                        begin
                            if (int'(step_index) < int'(pcnt_reg))
                            begin
                                state_next = gas_pkg::S_PRD;
                            end
                            else
                            begin
                                status_next = gas_pkg::ST_INVALID;
                                done_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = gas_pkg::ST_INVALID;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end

            gas_pkg::S_PRD:
            begin
                status_next = gas_pkg::ST_OK;
                srow_next   = 5'(pt_q[RW+CW-1:CW]);
                scol_next   = 4'(pt_q[CW-1:0]);
                done_next   = 1'b1;
                state_next  = gas_pkg::S_IDLE;
            end

            gas_pkg::S_BLK1:
            begin
                // start cell wall bit is in; fetch the goal cell
                map_ra = cell_of(gr_reg, gc_reg);
                if (map_q)
                begin
                    pcnt_next   = '0;
                    status_next = gas_pkg::ST_BLOCKED;
                    done_next   = 1'b1;
                    state_next  = gas_pkg::S_IDLE;
                end
                else
                begin
                    state_next = gas_pkg::S_BLK2;
                end
            end

            gas_pkg::S_BLK2:
            begin
                if (map_q)
                begin
                    pcnt_next   = '0;
                    status_next = gas_pkg::ST_BLOCKED;
                    done_next   = 1'b1;
                    state_next  = gas_pkg::S_IDLE;
                end
                else if (sr_reg == gr_reg && sc_reg == gc_reg)
                begin
                    pt_we       = 1'b1;
                    pt_wa       = '0;
                    pt_wd       = {sr_reg, sc_reg};
                    pcnt_next   = PW'(1);
                    status_next = gas_pkg::ST_ALREADY;
                    done_next   = 1'b1;
                    state_next  = gas_pkg::S_IDLE;
                end
                else
                begin
                    clr_next   = '0;
                    state_next = gas_pkg::S_CLR;
                end
            end

            gas_pkg::S_CLR:
            begin
                // clear closed marks, then seed the heap with the start node
                cls_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CELL_W'(CELLS - 1))
                begin
                    nd_we      = 1'b1;
                    nd_wa      = '0;
                    nd_wd      = '{row: sr_reg, col: sc_reg, has_par: 1'b0,
                                   par: '0, g: '0};
                    hp_we      = 1'b1;
                    hp_wa      = '0;
                    hp_wd      = '0;
                    hcnt_next  = (NW + 1)'(1);
                    ncnt_next  = (NW + 1)'(1);
                    state_next = gas_pkg::S_POP;
                end
            end

            gas_pkg::S_POP:
            begin
                if (hcnt_reg == '0)
                begin
                    pcnt_next   = '0;
                    status_next = gas_pkg::ST_NO_PATH;
                    done_next   = 1'b1;
                    state_next  = gas_pkg::S_IDLE;
                end
                else
                begin
                    hp_ra0     = '0;
                    hp_ra1     = NW'(hcnt_reg - 1'b1);
                    hcnt_next  = hcnt_reg - 1'b1;
                    state_next = gas_pkg::S_POP_Q;
                end
            end

            gas_pkg::S_POP_Q:
            begin
                top_next   = hp_q0;
                last_next  = hp_q1;
                hidx_next  = '0;
                state_next = gas_pkg::S_SD;
            end

            gas_pkg::S_SD:
            begin
                // fetch both children of the hole
                if (lc >= hcnt_reg)
                begin
                    state_next = gas_pkg::S_SD_END;
                end
                else
                begin
                    state_next = gas_pkg::S_SD_Q;
                end
            end

            gas_pkg::S_SD_Q:
            begin
                if (sv < last_reg)
                begin
                    hp_we      = 1'b1;
                    hp_wd      = sv;
                    hidx_next  = pick_r ? NW'(lc1) : NW'(lc);
                    state_next = gas_pkg::S_SD;
                end
                else
                begin
                    state_next = gas_pkg::S_SD_END;
                end
            end

            gas_pkg::S_SD_END:
            begin
                hp_we      = (hcnt_reg != '0);
                hp_wd      = last_reg;
                cur_next   = top_reg[NW-1:0];
                nd_ra      = top_reg[NW-1:0];
                state_next = gas_pkg::S_NODE_Q;
            end

            gas_pkg::S_NODE_Q:
            begin
                cur_r_next = nd_q.row;
                cur_c_next = nd_q.col;
                cur_g_next = nd_q.g;
                cls_ra     = cell_of(nd_q.row, nd_q.col);
                state_next = gas_pkg::S_CL_Q;
            end

            gas_pkg::S_CL_Q:
            begin
                // drop a node whose cell is closed, else close it and expand it (or walk the path at the goal)
                if (cls_q)
                begin
                    state_next = gas_pkg::S_POP;
                end
                else
                begin
                    cls_we = 1'b1;
                    cls_wa = cell_of(cur_r_reg, cur_c_reg);
                    cls_wd = 1'b1;
                    if (exp_reg != 16'hFFFF)
                    begin
                        exp_next = exp_reg + 1'b1;
                    end
                    if (cur_r_reg == gr_reg && cur_c_reg == gc_reg)
                    begin
                        walk_next  = '0;
                        state_next = gas_pkg::S_PW;
                    end
                    else
                    begin
                        di_next    = '0;
                        dj_next    = '0;
                        state_next = gas_pkg::S_NB;
                    end
                end
            end

            gas_pkg::S_NB:
            begin
                if (nb_ok)
                begin
                    state_next = gas_pkg::S_NB_Q;
                end
                else
                begin
                    dj_next    = (dj_reg == 2'd2) ? 2'd0 : dj_reg + 1'b1;
                    di_next    = (dj_reg == 2'd2) ? di_reg + 1'b1 : di_reg;
                    state_next = nb_last ? gas_pkg::S_POP : gas_pkg::S_NB;
                end
            end

            gas_pkg::S_NB_Q:
            begin
                if (map_q || cls_q)
                begin
                    dj_next    = (dj_reg == 2'd2) ? 2'd0 : dj_reg + 1'b1;
                    di_next    = (dj_reg == 2'd2) ? di_reg + 1'b1 : di_reg;
                    state_next = nb_last ? gas_pkg::S_POP : gas_pkg::S_NB;
                end
                else if (ncnt_reg == (NW + 1)'(NODE_DEPTH))
                begin
                    pcnt_next   = '0;
                    status_next = gas_pkg::ST_OVERFLOW;
                    done_next   = 1'b1;
                    state_next  = gas_pkg::S_IDLE;
                end
                else
                begin
                    sq_go      = 1'b1;
                    state_next = gas_pkg::S_H;
                end
            end

            gas_pkg::S_H:
            begin
                // store the new node once its distance estimate is in
                if (sq_done)
                begin
                    nd_we      = 1'b1;
                    ent_next   = {f_new, NW'(ncnt_reg)};
                    hidx_next  = NW'(hcnt_reg);
                    hcnt_next  = hcnt_reg + 1'b1;
                    ncnt_next  = ncnt_reg + 1'b1;
                    state_next = gas_pkg::S_SU;
                end
            end

            gas_pkg::S_SU:
            begin
                if (hidx_reg == '0)
                begin
                    hp_we      = 1'b1;
                    dj_next    = (dj_reg == 2'd2) ? 2'd0 : dj_reg + 1'b1;
                    di_next    = (dj_reg == 2'd2) ? di_reg + 1'b1 : di_reg;
                    state_next = nb_last ? gas_pkg::S_POP : gas_pkg::S_NB;
                end
                else
                begin
                    hp_ra0     = par_i;
                    state_next = gas_pkg::S_SU_Q;
                end
            end

            gas_pkg::S_SU_Q:
            begin
                // climb while the new word beats its parent
                hp_we = 1'b1;
                if (ent_reg < hp_q0)
                begin
                    hp_wd      = hp_q0;
                    hidx_next  = par_i;
                    state_next = gas_pkg::S_SU;
                end
                else
                begin
                    dj_next    = (dj_reg == 2'd2) ? 2'd0 : dj_reg + 1'b1;
                    di_next    = (dj_reg == 2'd2) ? di_reg + 1'b1 : di_reg;
                    state_next = nb_last ? gas_pkg::S_POP : gas_pkg::S_NB;
                end
            end

            gas_pkg::S_PW:
            begin
                nd_ra      = cur_reg;
                state_next = gas_pkg::S_PW_Q;
            end

            gas_pkg::S_PW_Q:
            begin
                // store the path goal first; reads reverse the index
                pt_we = 1'b1;
                if (nd_q.has_par && (int'(walk_reg) + 1 < CELLS))
                begin
                    cur_next   = nd_q.par;
                    walk_next  = walk_reg + 1'b1;
                    state_next = gas_pkg::S_PW;
                end
                else
                begin
                    pcnt_next   = PW'(walk_reg) + PW'(1);
                    status_next = gas_pkg::ST_FOUND;
                    done_next   = 1'b1;
                    state_next  = gas_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = gas_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gas_pkg::S_MAPCLR;
            clr_reg   <= '0;
            hcnt_reg  <= '0;
            ncnt_reg  <= '0;
            pcnt_reg  <= '0;
            exp_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hcnt_reg  <= hcnt_next;
            ncnt_reg  <= ncnt_next;
            pcnt_reg  <= pcnt_next;
            exp_reg   <= exp_next;
            done_reg  <= done_next;
        end
    end

    // hold datapath
    always_ff @(posedge clk)
    begin
        sr_reg     <= sr_next;
        sc_reg     <= sc_next;
        gr_reg     <= gr_next;
        gc_reg     <= gc_next;
        top_reg    <= top_next;
        last_reg   <= last_next;
        ent_reg    <= ent_next;
        hidx_reg   <= hidx_next;
        cur_reg    <= cur_next;
        cur_r_reg  <= cur_r_next;
        cur_c_reg  <= cur_c_next;
        cur_g_reg  <= cur_g_next;
        di_reg     <= di_next;
        dj_reg     <= dj_next;
        walk_reg   <= walk_next;
        status_reg <= status_next;
        srow_reg   <= srow_next;
        scol_reg   <= scol_next;
    end

    assign busy        = (state_reg != gas_pkg::S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign path_length = 10'(pcnt_reg);
    assign step_row    = srow_reg;
    assign step_col    = scol_reg;
    assign expansions  = exp_reg;

    a_heap_le_nodes: assert property (@(posedge clk) disable iff (!rst_n)
        hcnt_reg <= ncnt_reg)
        else $error("open heap holds more words than nodes");

    a_nodes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ncnt_reg <= (NW + 1)'(NODE_DEPTH))
        else $error("node count past store depth");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy || start))
        else $error("result word without an item");

    a_path_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pcnt_reg) <= CELLS)
        else $error("path count past path store depth");

endmodule

// ===== verif/tb_grid_astar_path_search_core.sv =====
// Self-checking testbench for grid_astar_path_search_core: a queue-fed driver,
// a clocked monitor and an in-bench A* predictor of map, search and path reads.
// Depends on gas_pkg and the core RTL only.
module tb_grid_astar_path_search_core;
    import gas_pkg::*;

    localparam int NR = ROWS_DEF;
    localparam int NC = COLS_DEF;
    localparam int NCELL = NR * NC;
    localparam int NDEP = NODE_DEPTH_DEF;
    localparam int HF = H_FRAC_BITS_DEF;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] cell_row;
        logic [3:0] cell_col;
        logic       wall;
        logic [4:0] start_row;
        logic [3:0] start_col;
        logic [4:0] goal_row;
        logic [3:0] goal_col;
        logic [8:0] step_index;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  path_length;
        logic [4:0]  step_row;
        logic [3:0]  step_col;
        logic [15:0] expansions;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_idx = 1'b0;
    logic [5:0] cfg_data = '0;
    item_t shown = '0;
    logic busy, done;
    logic [2:0] status;
    logic [9:0] path_length;
    logic [4:0] step_row;
    logic [3:0] step_col;
    logic [15:0] expansions;

    item_t pending_words[$];
    answer_t expected_answers[$];
    int gap_pct = 0;
    int mismatches = 0;
    int accepted = 0;

    // predictor state
    logic [5:0] rows_reg = ROWS_IN_USE_RST;
    logic [4:0] cols_reg = COLS_IN_USE_RST;
    bit map_wall[NCELL];
    bit closed[NCELL];
    int unsigned n_row[NDEP], n_col[NDEP], n_par[NDEP], n_g[NDEP], n_f[NDEP];
    bit n_haspar[NDEP];
    int unsigned n_count, h_count;
    int unsigned heap[NDEP];
    int unsigned p_row[NCELL], p_col[NCELL];
    int unsigned p_count = 0;
    int unsigned exp_total = 0;

    always #2 clk = ~clk;

    grid_astar_path_search_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(shown.kind), .cell_row(shown.cell_row), .cell_col(shown.cell_col),
        .wall(shown.wall), .start_row(shown.start_row), .start_col(shown.start_col),
        .goal_row(shown.goal_row), .goal_col(shown.goal_col),
        .step_index(shown.step_index), .done(done), .status(status),
        .path_length(path_length), .step_row(step_row), .step_col(step_col),
        .expansions(expansions), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Euclidean distance to the goal, rounded, HF fraction bits
    function automatic int unsigned dist_est(int unsigned r, int unsigned c,
                                             int unsigned gr, int unsigned gc);
        longint unsigned dr, dc, y;
        dr = r > gr ? r - gr : gr - r;
        dc = c > gc ? c - gc : gc - c;
        y = (dr * dr + dc * dc) << (2 * HF + 2);
        return int'((int_sqrt(y) + 1) >> 1);
    endfunction

    function automatic bit earlier(int unsigned a, int unsigned b);
        return n_f[a] < n_f[b] || (n_f[a] == n_f[b] && a < b);
    endfunction

    function automatic void add_node(int unsigned r, int unsigned c, bit hp,
                                     int unsigned par, int unsigned g, int unsigned f);
        int unsigned n, i, p;
        n = n_count++;
        n_row[n] = r; n_col[n] = c; n_haspar[n] = hp;
        n_par[n] = par; n_g[n] = g; n_f[n] = f;
        i = h_count++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!earlier(n, heap[p])) break;
            heap[i] = heap[p];
            i = p;
        end
        heap[i] = n;
    endfunction

    function automatic int unsigned take_best();
        int unsigned top, last, i, l, s;
        top = heap[0];
        last = heap[--h_count];
        i = 0;
        forever begin
            l = 2 * i + 1;
            if (l >= h_count) break;
            s = l;
            if (l + 1 < h_count && earlier(heap[l + 1], heap[l])) s = l + 1;
            if (!earlier(heap[s], last)) break;
            heap[i] = heap[s];
            i = s;
        end
        if (h_count > 0) heap[i] = last;
        return top;
    endfunction

    function automatic void keep_path(int unsigned n);
        int unsigned len, k, i;
        len = 1;
        k = n;
        while (n_haspar[k] && len < NCELL) begin
            k = n_par[k];
            len++;
        end
        p_count = len;
        k = n;
        for (i = len; i > 0; i--) begin
            p_row[i - 1] = n_row[k];
            p_col[i - 1] = n_col[k];
            k = n_par[k];
        end
    endfunction

    function automatic logic [2:0] run_search(int unsigned sr, int unsigned sc,
                                              int unsigned gr, int unsigned gc);
        int unsigned nr, nc, cur, r, c, ur, uc, g;
        int ir, ic;
        nr = rows_reg < NR ? rows_reg : NR;
        nc = cols_reg < NC ? cols_reg : NC;
        p_count = 0;
        if (sr >= nr || sc >= nc || gr >= nr || gc >= nc) return ST_INVALID;
        if (map_wall[sr * NC + sc] || map_wall[gr * NC + gc]) return ST_BLOCKED;
        if (sr == gr && sc == gc) begin
            p_row[0] = sr; p_col[0] = sc; p_count = 1;
            return ST_ALREADY;
        end
        foreach (closed[i]) closed[i] = 1'b0;
        n_count = 0;
        h_count = 0;
        add_node(sr, sc, 1'b0, 0, 0, 0);
        while (h_count > 0) begin
            cur = take_best();
            r = n_row[cur];
            c = n_col[cur];
            if (closed[r * NC + c]) continue;
            closed[r * NC + c] = 1'b1;
            if (exp_total < 65535) exp_total++;
            if (r == gr && c == gc) begin
                keep_path(cur);
                return ST_FOUND;
            end
            for (int di = -1; di <= 1; di++) begin
                for (int dj = -1; dj <= 1; dj++) begin
                    ir = int'(r) + di;
                    ic = int'(c) + dj;
                    if (ir < 0 || ic < 0 || ir >= int'(nr) || ic >= int'(nc)) continue;
                    ur = ir;
                    uc = ic;
                    if (map_wall[ur * NC + uc] || closed[ur * NC + uc]) continue;
                    if (n_count >= NDEP) return ST_OVERFLOW;
                    g = n_g[cur] + 1;
                    add_node(ur, uc, 1'b1, cur, g, (g << HF) + dist_est(ur, uc, gr, gc));
                end
            end
        end
        return ST_NO_PATH;
    endfunction

    // work out the answer word for one accepted item
    function automatic answer_t predict_answer(item_t w);
        answer_t a;
        a = '0;
        a.status = ST_INVALID;
        case (w.kind)
            KIND_WRITE: begin
                map_wall[w.cell_row * NC + w.cell_col] = w.wall;
                a.status = ST_OK;
            end
            KIND_SEARCH: a.status = run_search(w.start_row, w.start_col,
                                               w.goal_row, w.goal_col);
            KIND_READ: begin
                if (w.step_index < p_count) begin
                    a.status = ST_OK;
                    a.step_row = p_row[w.step_index];
                    a.step_col = p_col[w.step_index];
                end
            end
            default: ;
        endcase
        a.path_length = p_count;
        a.expansions = exp_total;
        return a;
    endfunction

    // driver: predict on acceptance, then offer the next word or idle
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                expected_answers.push_back(predict_answer(shown));
                accepted++;
            end
            if (!start || !busy) begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
                    shown <= pending_words.pop_front();
                    start <= 1'b1;
                end
                else start <= 1'b0;
            end
        end
    end

    // monitor: compare each answer word with the oldest expectation
    always @(posedge clk) begin
        answer_t got, want;
        if (rst_n && done) begin
            got = {status, path_length, step_row, step_col, expansions};
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected answer word %h", got);
            end
            else begin
                want = expected_answers.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d len=%0d r=%0d c=%0d x=%0d, got st=%0d len=%0d r=%0d c=%0d x=%0d",
                                 want.status, want.path_length, want.step_row, want.step_col,
                                 want.expansions, got.status, got.path_length, got.step_row,
                                 got.step_col, got.expansions);
                end
            end
        end
    end

    task automatic drain();
        do @(posedge clk);
        while (pending_words.size() > 0 || start || expected_answers.size() > 0);
    endtask

    task automatic write_reg(logic idx, logic [5:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == REG_ROWS) rows_reg = val;
        else cols_reg = val[4:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic item_t make_word(logic [1:0] k);
        item_t w;
        w.kind = k;
        w.cell_row = $urandom; w.cell_col = $urandom; w.wall = $urandom;
        w.start_row = $urandom; w.start_col = $urandom;
        w.goal_row = $urandom; w.goal_col = $urandom;
        w.step_index = $urandom;
        return w;
    endfunction

    // random word, mostly inside the area in use so searches get deep
    function automatic item_t random_word();
        item_t w;
        int unsigned nr, nc, pick;
        nr = rows_reg < NR ? rows_reg : NR;
        nc = cols_reg < NC ? cols_reg : NC;
        if (nr == 0) nr = 1;
        if (nc == 0) nc = 1;
        pick = $urandom_range(0, 99);
        w = make_word(pick < 35 ? KIND_WRITE : pick < 65 ? KIND_SEARCH :
                      pick < 95 ? KIND_READ : 2'd3);
        if ($urandom_range(0, 9) > 0) begin
            w.cell_row = $urandom_range(0, nr - 1);
            w.cell_col = $urandom_range(0, nc - 1);
            w.wall = $urandom_range(0, 3) == 0;
            w.start_row = $urandom_range(0, nr - 1);
            w.start_col = $urandom_range(0, nc - 1);
            w.goal_row = $urandom_range(0, nr - 1);
            w.goal_col = $urandom_range(0, nc - 1);
            w.step_index = $urandom_range(0, 24);
        end
        return w;
    endfunction

    function automatic item_t search_word(int sr, int sc, int gr, int gc);
        item_t w;
        w = make_word(KIND_SEARCH);
        w.start_row = sr; w.start_col = sc; w.goal_row = gr; w.goal_col = gc;
        return w;
    endfunction

    function automatic item_t cell_word(int r, int c, bit blk);
        item_t w;
        w = make_word(KIND_WRITE);
        w.cell_row = r; w.cell_col = c; w.wall = blk;
        return w;
    endfunction

    function automatic item_t read_word(int idx);
        item_t w;
        w = make_word(KIND_READ);
        w.step_index = idx;
        return w;
    endfunction

    initial begin
        int rows_set[8] = '{1, 32, 4, 8, 63, 2, 32, 6};
        int cols_set[8] = '{1, 16, 4, 6, 31, 16, 1, 5};
        int gap_set[4] = '{0, 67, 25, 0};
        foreach (map_wall[i]) map_wall[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every kind and the invalid, blocked, same-cell and no-path cases
        pending_words.push_back(cell_word(31, 15, 1));
        pending_words.push_back(cell_word(0, 0, 0));
        pending_words.push_back(search_word(0, 0, 19, 15));
        pending_words.push_back(read_word(0));
        pending_words.push_back(read_word(19));
        pending_words.push_back(read_word(20));
        pending_words.push_back(read_word(511));
        pending_words.push_back(search_word(20, 0, 0, 0));
        pending_words.push_back(search_word(0, 0, 31, 15));
        pending_words.push_back(cell_word(5, 5, 1));
        pending_words.push_back(search_word(5, 5, 0, 0));
        pending_words.push_back(search_word(3, 3, 3, 3));
        pending_words.push_back(read_word(0));
        pending_words.push_back(read_word(1));
        pending_words.push_back(cell_word(1, 0, 1));
        pending_words.push_back(cell_word(1, 1, 1));
        pending_words.push_back(cell_word(0, 1, 1));
        pending_words.push_back(search_word(0, 0, 10, 10));
        pending_words.push_back(search_word(10, 10, 0, 0));
        pending_words.push_back(make_word(2'd3));
        pending_words.push_back(cell_word(1, 1, 0));
        pending_words.push_back(search_word(0, 0, 2, 2));
        pending_words.push_back(read_word(2));
        drain();

        // random phases over several grid sizes and idle mixes
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_ROWS, rows_set[ph]);
            write_reg(REG_COLS, cols_set[ph]);
            gap_pct = gap_set[ph % 4];
            for (int k = 0; k < 15; k++) pending_words.push_back(random_word());
            // hold off until every answer is back, then finish the phase
            drain();
            for (int k = 0; k < 2; k++) pending_words.push_back(random_word());
            drain();
        end
        write_reg(REG_ROWS, ROWS_IN_USE_RST);
        write_reg(REG_COLS, COLS_IN_USE_RST);

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("tb_grid_astar_path_search_core: PASS");
        else
            $display("tb_grid_astar_path_search_core: FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #60000000;
        $display("tb_grid_astar_path_search_core: FAIL");
        $finish;
    end
endmodule
